### hdl/rgb_to_hsv_macros.svh
// Assertion macros used by the checker of the color converter.
`ifndef RGB_TO_HSV_MACROS_SVH
`define RGB_TO_HSV_MACROS_SVH

// Plain property, sampled on the rising clock edge, ignored while in reset.
`define RTH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication with the consequent checked in the same cycle.
`define RTH_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication with the consequent checked in the next cycle.
`define RTH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/rth_pkg.sv
// Shared constants of the RGB to HSV converter.
`timescale 1ns / 1ps

package rth_pkg;

    // Default configuration of the converter.
    localparam int COMPONENT_BITS_DEF = 8;
    localparam int HUE_FRAC_BITS_DEF  = 6;

    // Whole-degree part of the hue: 0 .. 359 needs nine bits.
    localparam int HUE_INT_BITS = 9;

    // Degrees per hue sector and degrees in a full turn.
    localparam int HUE_SECTOR_DEG = 60;
    localparam int HUE_FULL_DEG   = 360;

endpackage

### hdl/rth_if.sv
// Stream interfaces for RGB pixel beats and HSV pixel beats.
`timescale 1ns / 1ps

interface rth_pix_if #(
    parameter int CB = rth_pkg::COMPONENT_BITS_DEF
);
    logic          valid;
    logic          ready;
    logic [CB-1:0] red;
    logic [CB-1:0] green;
    logic [CB-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rth_hsv_if #(
    parameter int CB = rth_pkg::COMPONENT_BITS_DEF,
    parameter int HW = rth_pkg::HUE_INT_BITS + rth_pkg::HUE_FRAC_BITS_DEF
);
    logic          valid;
    logic          ready;
    logic [HW-1:0] hue;
    logic [CB-1:0] saturation;
    logic [CB-1:0] brightness;

    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    output ready);
endinterface

### hdl/rgb_to_hsv.sv
// Top level of the RGB to HSV converter: input skid, front stage, divider cell row.
`timescale 1ns / 1ps

// Channel | Direction | Beat contents
// pix     | in        | red, green, blue (COMPONENT_BITS each, unsigned)
// hsv     | out       | hue (9 + HUE_FRAC_BITS), saturation, brightness
//
// One pixel is accepted per clock while the input skid is empty; each result
// is registered in the front stage and then in every cell of the divider row.
// Reset clears the valid bits of the skid, the front stage and every cell.
// When hsv stalls, the whole row holds; one beat offered during that cycle
// lands in the input skid, so pix.ready comes straight from a register.

module rgb_to_hsv #(
    parameter int COMPONENT_BITS = rth_pkg::COMPONENT_BITS_DEF,
    parameter int HUE_FRAC_BITS  = rth_pkg::HUE_FRAC_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    rth_pix_if.sink    pix,
    rth_hsv_if.source  hsv
);
    import rth_pkg::*;

    localparam int CB = COMPONENT_BITS;
    localparam int HF = HUE_FRAC_BITS;
    localparam int HW = HUE_INT_BITS + HF;

    // The saturation quotient takes CB steps and the hue quotient HW steps.
    // The row is as long as the longer one; the shorter lane sits idle in
    // the leading cells so both finish in the last cell.
    localparam int NCELLS = (CB > HW) ? CB : HW;

    // Input skid buffer.
    logic          skid_valid_reg;
    logic          skid_valid_next;
    logic [CB-1:0] skid_red_reg;
    logic [CB-1:0] skid_green_reg;
    logic [CB-1:0] skid_blue_reg;

    logic          src_valid;
    logic [CB-1:0] src_red;
    logic [CB-1:0] src_green;
    logic [CB-1:0] src_blue;

    // Global advance: the row moves whenever the final register is free or drains.
    logic          en;

    // Stage signals; index 0 is the front stage, index NCELLS the last cell.
    logic          valid_c   [0:NCELLS];
    logic [CB-1:0] bright_c  [0:NCELLS];
    logic [CB-1:0] sat_div_c [0:NCELLS];
    logic [CB-1:0] sat_rem_c [0:NCELLS];
    logic [CB-1:0] sat_low_c [0:NCELLS];
    logic [CB-1:0] hue_div_c [0:NCELLS];
    logic [CB-1:0] hue_rem_c [0:NCELLS];
    logic [HW-1:0] hue_low_c [0:NCELLS];

    assign en        = hsv.ready || !valid_c[NCELLS];
    assign pix.ready = !skid_valid_reg;

    // A held beat in the skid goes first; pix cannot be accepted meanwhile.
    assign src_valid = skid_valid_reg || pix.valid;
    assign src_red   = skid_valid_reg ? skid_red_reg   : pix.red;
    assign src_green = skid_valid_reg ? skid_green_reg : pix.green;
    assign src_blue  = skid_valid_reg ? skid_blue_reg  : pix.blue;

    always_comb
    begin
        if (en)
        begin
            skid_valid_next = 1'b0;
        end
        else
        begin
            skid_valid_next = skid_valid_reg || pix.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!en && !skid_valid_reg && pix.valid)
        begin
            skid_red_reg   <= pix.red;
            skid_green_reg <= pix.green;
            skid_blue_reg  <= pix.blue;
        end
    end

    rth_front #(
        .CB (CB),
        .HF (HF)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .valid_in    (src_valid),
        .red         (src_red),
        .green       (src_green),
        .blue        (src_blue),
        .valid_reg   (valid_c[0]),
        .bright_reg  (bright_c[0]),
        .sat_div_reg (sat_div_c[0]),
        .sat_rem_reg (sat_rem_c[0]),
        .sat_low_reg (sat_low_c[0]),
        .hue_div_reg (hue_div_c[0]),
        .hue_rem_reg (hue_rem_c[0]),
        .hue_low_reg (hue_low_c[0])
    );

    for (genvar i = 0; i < NCELLS; i++)
    begin : g_cell
        rth_cell #(
            .CB     (CB),
            .HF     (HF),
            .SAT_ON (i >= NCELLS - CB),
            .HUE_ON (i >= NCELLS - HW)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .en          (en),
            .valid_in    (valid_c[i]),
            .bright_in   (bright_c[i]),
            .sat_div_in  (sat_div_c[i]),
            .sat_rem_in  (sat_rem_c[i]),
            .sat_low_in  (sat_low_c[i]),
            .hue_div_in  (hue_div_c[i]),
            .hue_rem_in  (hue_rem_c[i]),
            .hue_low_in  (hue_low_c[i]),
            .valid_reg   (valid_c[i+1]),
            .bright_reg  (bright_c[i+1]),
            .sat_div_reg (sat_div_c[i+1]),
            .sat_rem_reg (sat_rem_c[i+1]),
            .sat_low_reg (sat_low_c[i+1]),
            .hue_div_reg (hue_div_c[i+1]),
            .hue_rem_reg (hue_rem_c[i+1]),
            .hue_low_reg (hue_low_c[i+1])
        );
    end

    // After the last step the low words hold the quotients.
    assign hsv.valid      = valid_c[NCELLS];
    assign hsv.hue        = hue_low_c[NCELLS];
    assign hsv.saturation = sat_low_c[NCELLS];
    assign hsv.brightness = bright_c[NCELLS];

endmodule

### hdl/rth_front.sv
// Front stage: max, min, sector offset and the two divider setups, registered.
`timescale 1ns / 1ps

module rth_front #(
    parameter int CB = rth_pkg::COMPONENT_BITS_DEF,
    parameter int HF = rth_pkg::HUE_FRAC_BITS_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      en,
    input  logic                                      valid_in,
    input  logic [CB-1:0]                             red,
    input  logic [CB-1:0]                             green,
    input  logic [CB-1:0]                             blue,
    output logic                                      valid_reg,
    output logic [CB-1:0]                             bright_reg,
    output logic [CB-1:0]                             sat_div_reg,
    output logic [CB-1:0]                             sat_rem_reg,
    output logic [CB-1:0]                             sat_low_reg,
    output logic [CB-1:0]                             hue_div_reg,
    output logic [CB-1:0]                             hue_rem_reg,
    output logic [rth_pkg::HUE_INT_BITS+HF-1:0]       hue_low_reg
);
    import rth_pkg::*;

    localparam int HW = HUE_INT_BITS + HF;
    localparam int NW = CB + 4;     // sector sum, with room for a negative difference
    localparam int PW = CB + 3;     // sector sum after wrap, below 6 * delta
    localparam int MW = PW + 6;     // sector sum times 60
    localparam int DW = MW + HF;    // hue dividend

    logic [CB-1:0]   mx;
    logic [CB-1:0]   mn;
    logic [CB-1:0]   delta;
    logic [NW-1:0]   delta_w;
    logic [NW-1:0]   n_w;
    logic [PW-1:0]   n;
    logic [MW-1:0]   n60;
    logic [DW-1:0]   hue_dvd;
    logic [2*CB-1:0] sat_dvd;

    logic            valid_next;
    logic [CB-1:0]   bright_next;
    logic [CB-1:0]   sat_div_next;
    logic [CB-1:0]   sat_rem_next;
    logic [CB-1:0]   sat_low_next;
    logic [CB-1:0]   hue_div_next;
    logic [CB-1:0]   hue_rem_next;
    logic [HW-1:0]   hue_low_next;

    always_comb
    begin
        mx = red;
        mn = red;
        if (green > mx)
        begin
            mx = green;
        end
        if (blue > mx)
        begin
            mx = blue;
        end
        if (green < mn)
        begin
            mn = green;
        end
        if (blue < mn)
        begin
            mn = blue;
        end
        delta   = mx - mn;
        delta_w = NW'(delta);

        // Modular arithmetic in NW bits; the true sum is never negative after the wrap.
        if (red >= green && red >= blue)
        begin
            n_w = NW'(green) - NW'(blue);
            if (green < blue)
            begin
                n_w = n_w + (delta_w << 2) + (delta_w << 1);
            end
        end
        else if (green >= blue)
        begin
            n_w = (delta_w << 1) + NW'(blue) - NW'(red);
        end
        else
        begin
            n_w = (delta_w << 2) + NW'(red) - NW'(green);
        end
        n = n_w[PW-1:0];

        n60     = (MW'(n) << 6) - (MW'(n) << 2);
        hue_dvd = DW'(n60) << HF;
        sat_dvd = (2*CB)'((2*CB)'(delta) << CB) - (2*CB)'(delta);

        valid_next   = valid_in;
        bright_next  = mx;
        // A zero divisor is replaced by all ones; its dividend is zero then,
        // so the quotient comes out zero, which is the grey and black answer.
        sat_div_next = (mx == '0) ? '1 : mx;
        hue_div_next = (delta == '0) ? '1 : delta;
        sat_rem_next = sat_dvd[2*CB-1:CB];
        sat_low_next = sat_dvd[CB-1:0];
        hue_rem_next = hue_dvd[DW-1:HW];
        hue_low_next = hue_dvd[HW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bright_reg  <= bright_next;
            sat_div_reg <= sat_div_next;
            sat_rem_reg <= sat_rem_next;
            sat_low_reg <= sat_low_next;
            hue_div_reg <= hue_div_next;
            hue_rem_reg <= hue_rem_next;
            hue_low_reg <= hue_low_next;
        end
    end

endmodule

### hdl/rth_cell.sv
// One divider cell: a restoring step for the saturation lane and the hue lane.
`timescale 1ns / 1ps

module rth_cell #(
    parameter int CB     = rth_pkg::COMPONENT_BITS_DEF,
    parameter int HF     = rth_pkg::HUE_FRAC_BITS_DEF,
    parameter bit SAT_ON = 1'b1,
    parameter bit HUE_ON = 1'b1
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                valid_in,
    input  logic [CB-1:0]                       bright_in,
    input  logic [CB-1:0]                       sat_div_in,
    input  logic [CB-1:0]                       sat_rem_in,
    input  logic [CB-1:0]                       sat_low_in,
    input  logic [CB-1:0]                       hue_div_in,
    input  logic [CB-1:0]                       hue_rem_in,
    input  logic [rth_pkg::HUE_INT_BITS+HF-1:0] hue_low_in,
    output logic                                valid_reg,
    output logic [CB-1:0]                       bright_reg,
    output logic [CB-1:0]                       sat_div_reg,
    output logic [CB-1:0]                       sat_rem_reg,
    output logic [CB-1:0]                       sat_low_reg,
    output logic [CB-1:0]                       hue_div_reg,
    output logic [CB-1:0]                       hue_rem_reg,
    output logic [rth_pkg::HUE_INT_BITS+HF-1:0] hue_low_reg
);
    import rth_pkg::*;

    localparam int HW = HUE_INT_BITS + HF;

    logic [CB:0]   sat_t;
    logic          sat_ge;
    logic [CB:0]   hue_t;
    logic          hue_ge;
    logic [CB-1:0] sat_rem_next;
    logic [CB-1:0] sat_low_next;
    logic [CB-1:0] hue_rem_next;
    logic [HW-1:0] hue_low_next;

    // Shift the next dividend bit into the partial remainder, subtract the
    // divisor when it fits, and shift the quotient bit into the low word.
    always_comb
    begin
        sat_t  = {sat_rem_in, sat_low_in[CB-1]};
        sat_ge = (sat_t >= {1'b0, sat_div_in});
        hue_t  = {hue_rem_in, hue_low_in[HW-1]};
        hue_ge = (hue_t >= {1'b0, hue_div_in});

        if (SAT_ON)
        begin
            sat_rem_next = sat_ge ? CB'(sat_t - {1'b0, sat_div_in}) : sat_t[CB-1:0];
            sat_low_next = {sat_low_in[CB-2:0], sat_ge};
        end
        else
        begin
            sat_rem_next = sat_rem_in;
            sat_low_next = sat_low_in;
        end

        if (HUE_ON)
        begin
            hue_rem_next = hue_ge ? CB'(hue_t - {1'b0, hue_div_in}) : hue_t[CB-1:0];
            hue_low_next = {hue_low_in[HW-2:0], hue_ge};
        end
        else
        begin
            hue_rem_next = hue_rem_in;
            hue_low_next = hue_low_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bright_reg  <= bright_in;
            sat_div_reg <= sat_div_in;
            sat_rem_reg <= sat_rem_next;
            sat_low_reg <= sat_low_next;
            hue_div_reg <= hue_div_in;
            hue_rem_reg <= hue_rem_next;
            hue_low_reg <= hue_low_next;
        end
    end

endmodule

### hdl/rth_checker.sv
// Port-level checker of the RGB to HSV converter and its bind statement.
`timescale 1ns / 1ps
`include "rgb_to_hsv_macros.svh"

module rth_checker #(
    parameter int CB = rth_pkg::COMPONENT_BITS_DEF,
    parameter int HF = rth_pkg::HUE_FRAC_BITS_DEF
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                hsv_valid,
    input logic                                hsv_ready,
    input logic [rth_pkg::HUE_INT_BITS+HF-1:0] hsv_hue,
    input logic [CB-1:0]                       hsv_saturation,
    input logic [CB-1:0]                       hsv_brightness
);
    import rth_pkg::*;

    localparam int HW = HUE_INT_BITS + HF;
    localparam logic [HW-1:0] HUE_LIMIT = HW'(HUE_FULL_DEG << HF);

    // A stalled result beat keeps its value until it is taken.
    `RTH_ASSERT_NEXT(a_out_hold, hsv_valid && !hsv_ready, hsv_valid && $stable(hsv_hue) && $stable(hsv_saturation) && $stable(hsv_brightness), "stalled result beat changed")

    // The hue stays below a full turn.
    `RTH_ASSERT_IMPL(a_hue_range, hsv_valid, hsv_hue < HUE_LIMIT, "hue beyond a full turn")

    // A black pixel gives no hue and no saturation.
    `RTH_ASSERT_IMPL(a_black, hsv_valid && hsv_brightness == '0, hsv_hue == '0 && hsv_saturation == '0, "black pixel with color")

    // Zero saturation means a grey pixel, which has no hue.
    `RTH_ASSERT_IMPL(a_grey, hsv_valid && hsv_saturation == '0, hsv_hue == '0, "grey pixel with hue")

    // No result beat is valid in the cycle in which reset is released.
    `RTH_ASSERT(a_reset_quiet, !$rose(rst_n) || !hsv_valid, "result beat right after reset")

endmodule

bind rgb_to_hsv rth_checker #(
    .CB (COMPONENT_BITS),
    .HF (HUE_FRAC_BITS)
) u_rth_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .hsv_valid      (hsv.valid),
    .hsv_ready      (hsv.ready),
    .hsv_hue        (hsv.hue),
    .hsv_saturation (hsv.saturation),
    .hsv_brightness (hsv.brightness)
);
